// ----- src/multiply_xor_block_hash256_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multiply-XOR block hash
// Shared property shapes used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MULTIPLY_XOR_BLOCK_HASH256_ASSERT_SVH
`define MULTIPLY_XOR_BLOCK_HASH256_ASSERT_SVH

// A condition must be followed by another one a fixed number of cycles later.
`define MXH_ASSERT_DELAY(name, clk, rst, ante, n, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("mxh: delayed check failed");

// A condition must be followed by another one in the next cycle, reset included.
`define MXH_ASSERT_NEXT(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("mxh: next-cycle check failed");

`endif

// ----- src/mxh_pkg.sv -----
// ----------------------------------------------------------------------------
// Multiply-XOR block hash package
// Word and carry types, seed constants and pipeline dimensions.
// ----------------------------------------------------------------------------
package mxh_pkg;

   typedef logic [63:0] word_type;

   // Words 0..3 are the working state, 4 and 5 hold saved products, 6..9 the message.
   localparam int CarryWords = 10;
   typedef logic [CarryWords-1:0][63:0] carry_type;

   localparam int C_X  = 4;
   localparam int C_Y  = 5;
   localparam int C_M0 = 6;

   localparam int MXH_ROUNDS  = 8;
   localparam int MXH_LEVELS  = 19;
   localparam int MXH_LATENCY = 2 * MXH_LEVELS * MXH_ROUNDS + 1;

   localparam word_type SEED_0 = 64'ha7af31539e9190e7;
   localparam word_type SEED_1 = 64'ha293a5cc7f4400c8;
   localparam word_type SEED_2 = 64'h26458d663397c103;
   localparam word_type SEED_3 = 64'h99745a5c13c1216d;

endpackage

// ----- src/mxh_lvl.sv -----
// ----------------------------------------------------------------------------
// Multiply level
// Two 64-bit products modulo 2^64 over two register stages, carry delayed alongside.
// ----------------------------------------------------------------------------
module mxh_lvl
   import mxh_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  carry_type in_carry,
   input  word_type  a0,
   input  word_type  b0,
   input  word_type  a1,
   input  word_type  b1,
   output logic      out_valid,
   output carry_type out_carry,
   output word_type  p0,
   output word_type  p1
);

   logic        valid1_ff, valid2_ff;
   carry_type   carry1_ff, carry2_ff;
   logic [63:0] ll0_ff, ll1_ff;
   logic [31:0] lh0_ff, hl0_ff, lh1_ff, hl1_ff;
   word_type    p0_ff, p1_ff;
   logic [31:0] cross0_in, cross1_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      carry1_ff <= in_carry;
      ll0_ff    <= 64'(a0[31:0]) * 64'(b0[31:0]);
      lh0_ff    <= 32'(a0[31:0] * b0[63:32]);
      hl0_ff    <= 32'(a0[63:32] * b0[31:0]);
      ll1_ff    <= 64'(a1[31:0]) * 64'(b1[31:0]);
      lh1_ff    <= 32'(a1[31:0] * b1[63:32]);
      hl1_ff    <= 32'(a1[63:32] * b1[31:0]);
      carry2_ff <= carry1_ff;
      p0_ff     <= ll0_ff + {cross0_in, 32'd0};
      p1_ff     <= ll1_ff + {cross1_in, 32'd0};
   end

   assign cross0_in = lh0_ff + hl0_ff;
   assign cross1_in = lh1_ff + hl1_ff;

   assign out_valid = valid2_ff;
   assign out_carry = carry2_ff;
   assign p0        = p0_ff;
   assign p1        = p1_ff;

endmodule

// ----- src/mxh_round.sv -----
// ----------------------------------------------------------------------------
// Hash round
// Message injection and the three mixing boxes as nineteen multiply levels.
// ----------------------------------------------------------------------------
module mxh_round
   import mxh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [2:0] round_idx,
   input  logic       in_valid,
   input  carry_type  in_carry,
   output logic       out_valid,
   output carry_type  out_carry
);

   logic      src_v  [MXH_LEVELS];
   carry_type src_c  [MXH_LEVELS];
   word_type  src_p0 [MXH_LEVELS];
   word_type  src_p1 [MXH_LEVELS];
   logic      lvl_v  [MXH_LEVELS];
   carry_type lvl_c  [MXH_LEVELS];
   word_type  lvl_p0 [MXH_LEVELS];
   word_type  lvl_p1 [MXH_LEVELS];

   logic [2:0]  chunk_idx;
   word_type    chunk_word;
   logic [31:0] chunk;
   carry_type   inj_carry;

   always_comb begin
      chunk_idx  = 3'd7 - round_idx;
      chunk_word = in_carry[C_M0 + int'(chunk_idx[2:1])];
      chunk      = chunk_idx[0] ? chunk_word[63:32] : chunk_word[31:0];
      inj_carry  = in_carry;
      for (int k = 0; k < 4; k++) begin
         inj_carry[k] = in_carry[k] ^ ({56'd0, chunk[8*k +: 8]} << {round_idx, 3'd0});
      end
   end

   assign src_v[0]  = in_valid;
   assign src_c[0]  = inj_carry;
   assign src_p0[0] = '0;
   assign src_p1[0] = '0;

   for (genvar i = 0; i < MXH_LEVELS; i++) begin : g_lvl
      carry_type c;
      word_type  a0, b0, a1, b1, p0, p1;

      if (i > 0) begin : g_link
         assign src_v[i]  = lvl_v[i-1];
         assign src_c[i]  = lvl_c[i-1];
         assign src_p0[i] = lvl_p0[i-1];
         assign src_p1[i] = lvl_p1[i-1];
      end

      always_comb begin
         c  = src_c[i];
         p0 = src_p0[i];
         p1 = src_p1[i];
         a0 = '0;
         b0 = '0;
         a1 = '0;
         b1 = '0;
         case (i)
            0: begin
               a0 = (c[0] << 32) ^ (c[3] >> 32);
               b0 = c[0];
            end
            1: begin
               a0 = c[3];
               b0 = p0 + 64'd1;
            end
            2: begin
               c[3] = p0;
               a0   = (c[1] << 48) ^ (c[2] >> 16);
               b0   = c[1];
            end
            3: begin
               a0 = c[2];
               b0 = p0 + 64'd1;
            end
            4: begin
               c[2] = p0;
               a0   = (c[2] << 32) ^ (c[1] >> 32);
               b0   = c[2];
            end
            5: begin
               a0 = c[1];
               b0 = p0 + 64'd1;
            end
            6: begin
               c[1] = p0;
               a0   = (c[3] << 16) ^ (c[0] >> 48);
               b0   = c[3];
            end
            7: begin
               a0 = c[0];
               b0 = p0 + 64'd1;
            end
            8: begin
               c[0] = p0;
               a0   = c[3];
               b0   = ((c[0] << 32) ^ (c[3] >> 32)) + 64'd1;
            end
            9: begin
               c[3] = p0;
               a0   = c[2];
               b0   = ((c[1] << 32) ^ (c[2] >> 32)) + 64'd1;
            end
            10: begin
               c[2] = p0;
               a0   = c[1];
               b0   = ((c[2] << 32) ^ (c[1] >> 32)) + 64'd1;
            end
            11: begin
               c[1] = p0;
               a0   = c[0];
               b0   = ((c[3] << 32) ^ (c[0] >> 32)) + 64'd1;
            end
            12: begin
               c[0] = p0;
               a0   = c[0];
               b0   = c[1];
               a1   = c[2];
               b1   = c[3];
            end
            13: begin
               c[C_X] = p1;
               a0     = p0;
               b0     = p1;
               a1     = c[1];
               b1     = p1;
            end
            14: begin
               c[0]   = c[0] ^ (p0 + 64'd1);
               c[C_Y] = p1;
               a0     = c[0];
               b0     = p1;
            end
            15: begin
               c[1] = c[1] ^ (p0 + 64'd1);
               a0   = c[0];
               b0   = c[1];
            end
            16: begin
               c[C_Y] = p0;
               a0     = p0;
               b0     = c[C_X];
            end
            17: begin
               c[2] = c[2] ^ (p0 + 64'd1);
               a0   = c[2];
               b0   = c[3];
            end
            18: begin
               a0 = p0;
               b0 = c[C_Y];
            end
            default: begin
               a0 = '0;
            end
         endcase
      end

      mxh_lvl u_lvl (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (src_v[i]),
         .in_carry  (c),
         .a0        (a0),
         .b0        (b0),
         .a1        (a1),
         .b1        (b1),
         .out_valid (lvl_v[i]),
         .out_carry (lvl_c[i]),
         .p0        (lvl_p0[i]),
         .p1        (lvl_p1[i])
      );
   end

   always_comb begin
      out_carry    = lvl_c[MXH_LEVELS-1];
      out_carry[3] = lvl_c[MXH_LEVELS-1][3] ^ (lvl_p0[MXH_LEVELS-1] + 64'd1);
   end

   assign out_valid = lvl_v[MXH_LEVELS-1];

endmodule

// ----- src/multiply_xor_block_hash256.sv -----
// Path from the accepting edge: both stages of every level, then the digest register.
// Throughput: one transaction per cycle; busy stays low.
// The pipeline is 152 two-stage 64-bit multiply levels, 19 per round over 8 rounds.
// Reset clears every valid bit in the pipeline; data registers are not reset.
// The receiver cannot stall, so results never wait.
// ----------------------------------------------------------------------------
// Multiply-XOR block hash, 256-bit digest
// Fully pipelined hash of one 32-byte block into four 64-bit digest words.
// ----------------------------------------------------------------------------
`include "multiply_xor_block_hash256_assert.svh"

module multiply_xor_block_hash256
   import mxh_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  word_type req_block_word_0,
   input  word_type req_block_word_1,
   input  word_type req_block_word_2,
   input  word_type req_block_word_3,
   output logic     rsp_valid,
   output word_type rsp_digest_word_0,
   output word_type rsp_digest_word_1,
   output word_type rsp_digest_word_2,
   output word_type rsp_digest_word_3
);

   logic      rnd_v [MXH_ROUNDS+1];
   carry_type rnd_c [MXH_ROUNDS+1];

   logic      rsp_valid_ff;
   carry_type digest_ff;

   assign busy = 1'b0;

   always_comb begin
      rnd_c[0]         = '0;
      rnd_c[0][0]      = SEED_0;
      rnd_c[0][1]      = SEED_1;
      rnd_c[0][2]      = SEED_2;
      rnd_c[0][3]      = SEED_3;
      rnd_c[0][C_M0]   = req_block_word_0;
      rnd_c[0][C_M0+1] = req_block_word_1;
      rnd_c[0][C_M0+2] = req_block_word_2;
      rnd_c[0][C_M0+3] = req_block_word_3;
   end

   assign rnd_v[0] = start && !busy;

   for (genvar r = 0; r < MXH_ROUNDS; r++) begin : g_round
      mxh_round u_round (
         .clock     (clock),
         .reset     (reset),
         .round_idx (3'(r)),
         .in_valid  (rnd_v[r]),
         .in_carry  (rnd_c[r]),
         .out_valid (rnd_v[r+1]),
         .out_carry (rnd_c[r+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rnd_v[MXH_ROUNDS];
      end
   end

   always_ff @(posedge clock) begin
      digest_ff <= rnd_c[MXH_ROUNDS];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_digest_word_0 = digest_ff[0];
   assign rsp_digest_word_1 = digest_ff[1];
   assign rsp_digest_word_2 = digest_ff[2];
   assign rsp_digest_word_3 = digest_ff[3];

   `MXH_ASSERT_DELAY(a_latency, clock, reset, start && !busy, MXH_LATENCY, rsp_valid)
   `MXH_ASSERT_NEXT(a_reset_clears, clock, reset, !rsp_valid)

endmodule

// ----- sim/multiply_xor_block_hash256_tb.sv -----
// ----------------------------------------------------------------------------
// Multiply-XOR block hash testbench
// Sends message blocks through the start/busy handshake, predicts each digest
// with an independent model of the rounds and compares every strobed result
// field by field against the oldest pending digest.
// ----------------------------------------------------------------------------
module multiply_xor_block_hash256_tb;
   import mxh_pkg::*;

   typedef struct packed {
      word_type w0;
      word_type w1;
      word_type w2;
      word_type w3;
   } digest_type;

   logic     clock;
   logic     reset;
   logic     start;
   logic     busy;
   word_type req_block_word_0;
   word_type req_block_word_1;
   word_type req_block_word_2;
   word_type req_block_word_3;
   logic     rsp_valid;
   word_type rsp_digest_word_0;
   word_type rsp_digest_word_1;
   word_type rsp_digest_word_2;
   word_type rsp_digest_word_3;

   digest_type pending_digests[$];
   int error_count;
   int idle_percent;

   multiply_xor_block_hash256 dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_block_word_0(req_block_word_0), .req_block_word_1(req_block_word_1),
      .req_block_word_2(req_block_word_2), .req_block_word_3(req_block_word_3),
      .rsp_valid(rsp_valid),
      .rsp_digest_word_0(rsp_digest_word_0), .rsp_digest_word_1(rsp_digest_word_1),
      .rsp_digest_word_2(rsp_digest_word_2), .rsp_digest_word_3(rsp_digest_word_3)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("multiply_xor_block_hash256: mismatch");
      $finish;
   end

   function automatic digest_type hash_block(word_type b0, word_type b1, word_type b2,
                                             word_type b3);
      word_type st[4];
      logic [255:0] msg;
      word_type prod;
      msg = {b3, b2, b1, b0};
      st[0] = SEED_0;
      st[1] = SEED_1;
      st[2] = SEED_2;
      st[3] = SEED_3;
      for (int j = 0; j < 8; j++) begin
         for (int k = 0; k < 4; k++) begin
            st[k] ^= word_type'(msg[(28 - 4 * j + k) * 8 +: 8]) << (j * 8);
         end
         st[3] *= ((st[0] << 32) ^ (st[3] >> 32)) * st[0] + 64'd1;
         st[2] *= ((st[1] << 48) ^ (st[2] >> 16)) * st[1] + 64'd1;
         st[1] *= ((st[2] << 32) ^ (st[1] >> 32)) * st[2] + 64'd1;
         st[0] *= ((st[3] << 16) ^ (st[0] >> 48)) * st[3] + 64'd1;
         st[3] *= ((st[0] << 32) ^ (st[3] >> 32)) + 64'd1;
         st[2] *= ((st[1] << 32) ^ (st[2] >> 32)) + 64'd1;
         st[1] *= ((st[2] << 32) ^ (st[1] >> 32)) + 64'd1;
         st[0] *= ((st[3] << 32) ^ (st[0] >> 32)) + 64'd1;
         for (int k = 0; k < 4; k++) begin
            prod = st[0] * st[1] * st[2] * st[3];
            st[k] ^= prod + 64'd1;
         end
      end
      return '{st[0], st[1], st[2], st[3]};
   endfunction

   task automatic report_mismatch(string what, word_type got, word_type want);
      $display("digest %s: got %h, expected %h", what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      digest_type want;
      if (!reset && rsp_valid) begin
         if (pending_digests.size() == 0) begin
            $display("unexpected digest transaction");
            error_count++;
         end else begin
            want = pending_digests.pop_front();
            if (rsp_digest_word_0 !== want.w0) report_mismatch("word 0", rsp_digest_word_0, want.w0);
            if (rsp_digest_word_1 !== want.w1) report_mismatch("word 1", rsp_digest_word_1, want.w1);
            if (rsp_digest_word_2 !== want.w2) report_mismatch("word 2", rsp_digest_word_2, want.w2);
            if (rsp_digest_word_3 !== want.w3) report_mismatch("word 3", rsp_digest_word_3, want.w3);
         end
      end
   end

   function automatic word_type random_word();
      return {$urandom(), $urandom()};
   endfunction

   task automatic send_block(word_type b0, word_type b1, word_type b2, word_type b3);
      while ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_block_word_0 <= b0;
      req_block_word_1 <= b1;
      req_block_word_2 <= b2;
      req_block_word_3 <= b3;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_digests.push_back(hash_block(b0, b1, b2, b3));
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_digests.size() != 0) @(posedge clock);
   endtask

   task automatic test_extremes();
      idle_percent = 0;
      send_block('0, '0, '0, '0);
      send_block('1, '1, '1, '1);
      send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
                 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
      send_block(64'd1, 64'd0, 64'd0, 64'h8000000000000000);
      for (int i = 0; i < 4; i++) begin
         send_block(i == 0 ? '1 : '0, i == 1 ? '1 : '0, i == 2 ? '1 : '0, i == 3 ? '1 : '0);
      end
      for (int i = 0; i < 8; i++) begin
         send_block(64'hff << (8 * i), 64'd1 << (8 * i), 64'h80 << (8 * i), 64'h7f << (8 * i));
      end
      wait_drained();
   endtask

   task automatic test_random(int count, int idle);
      idle_percent = idle;
      for (int i = 0; i < count; i++) begin
         send_block(random_word(), random_word(), random_word(), random_word());
      end
   endtask

   initial begin
      error_count = 0;
      idle_percent = 0;
      reset = 1'b1;
      start = 1'b0;
      req_block_word_0 = '0;
      req_block_word_1 = '0;
      req_block_word_2 = '0;
      req_block_word_3 = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_random(230, 28);
      wait_drained();
      test_random(230, 87);
      test_random(240, 0);
      wait_drained();
      repeat (MXH_LATENCY + 20) @(posedge clock);
      if (error_count == 0) begin
         $display("multiply_xor_block_hash256: match");
      end else begin
         $display("multiply_xor_block_hash256: mismatch");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+src
src/mxh_pkg.sv
src/mxh_lvl.sv
src/mxh_round.sv
src/multiply_xor_block_hash256.sv
sim/multiply_xor_block_hash256_tb.sv
